### src/lrw_pkg.sv
// ----------------------------------------------------------------------------
// lrw_pkg: shared types and constants for the laser ray to world point block
// Holds the fixed-point constants, status codes, register indexes and the
// records that travel down the pipeline and through the output queue.
// ----------------------------------------------------------------------------
package lrw_pkg;

	localparam int MAX_RAYS   = 4096;
	localparam int ANGLE_BITS = 16;
	localparam int PHASE_BITS = 24;

	localparam logic [PHASE_BITS-1:0] PHASE_MASK =
		PHASE_BITS'(((64'd1 << PHASE_BITS) - 64'd1) &
		~((64'd1 << (PHASE_BITS - ANGLE_BITS)) - 64'd1));

	localparam logic [30:0] SIN_C1 = 31'd1686629713;
	localparam logic [30:0] SIN_C3 = 31'd693598669;
	localparam logic [30:0] SIN_C5 = 31'd85569306;
	localparam logic [30:0] SIN_C7 = 31'd5026995;
	localparam logic [30:0] SIN_C9 = 31'd172272;
	localparam logic [31:0] Q30_ONE = 32'd1073741824;

	localparam logic [15:0] QUARTER_TURN = 16'h4000;

	localparam int OQ_DEPTH = 32;
	localparam int OQ_AW    = 5;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_POSE  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_START_ANGLE = 3'd0,
		REG_ANGLE_STEP  = 3'd1,
		REG_RANGE_FLOOR = 3'd2,
		REG_RANGE_CEIL  = 3'd3,
		REG_MOUNT_X     = 3'd4,
		REG_MOUNT_Y     = 3'd5,
		REG_MOUNT_YAW   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [11:0]        idx;
		status_t            status;
		logic               last;
		logic [15:0]        range;
		logic signed [31:0] pe;
		logic signed [31:0] pn;
	} meta_t;

	typedef struct packed {
		logic signed [31:0] east;
		logic signed [31:0] north;
		logic [11:0]        ray_number;
		status_t            status;
		logic               scan_end;
	} res_t;

endpackage

### src/lrw_sin.sv
// ----------------------------------------------------------------------------
// lrw_sin: pipelined Q30 sine of a 16-bit binary angle
// Quadrant fold, then an odd degree-9 polynomial evaluated by Horner steps,
// one multiplication per stage, with a registered output.
// ----------------------------------------------------------------------------
module lrw_sin (
	input  logic               clk,
	input  logic [15:0]        angle,
	output logic signed [31:0] sin_q30
);

	logic [23:0] p;
	logic [22:0] x0;
	logic [22:0] x;
	logic [30:0] t;

	logic [30:0] t_s1, t_s2, t_s3, t_s4, t_s5;
	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [30:0] t2_s2, t2_s3, t2_s4;
	logic [61:0] m_s1, m_s2, m_s3, m_s4, m_s5, m_s6;
	logic [31:0] acc3, acc4, acc5, acc6;
	logic [31:0] mag;
	logic [31:0] mag_cl;

	assign p  = {angle, 8'd0} & lrw_pkg::PHASE_MASK;
	assign x0 = {1'b0, p[21:0]};
	assign x  = p[22] ? (23'h400000 - x0) : x0;
	assign t  = {x, 8'd0};

	assign acc3 = {1'b0, lrw_pkg::SIN_C7} - m_s2[61:30];
	assign acc4 = {1'b0, lrw_pkg::SIN_C5} - m_s3[61:30];
	assign acc5 = {1'b0, lrw_pkg::SIN_C3} - m_s4[61:30];
	assign acc6 = {1'b0, lrw_pkg::SIN_C1} - m_s5[61:30];

	assign mag    = m_s6[61:30];
	assign mag_cl = (mag > lrw_pkg::Q30_ONE) ? lrw_pkg::Q30_ONE : mag;

	always_ff @(posedge clk) begin
		t_s1   <= t;
		neg_s1 <= p[23];
		m_s1   <= t * t;

		t_s2   <= t_s1;
		neg_s2 <= neg_s1;
		t2_s2  <= m_s1[60:30];
		m_s2   <= lrw_pkg::SIN_C9 * m_s1[60:30];

		t_s3   <= t_s2;
		neg_s3 <= neg_s2;
		t2_s3  <= t2_s2;
		m_s3   <= acc3[30:0] * t2_s2;

		t_s4   <= t_s3;
		neg_s4 <= neg_s3;
		t2_s4  <= t2_s3;
		m_s4   <= acc4[30:0] * t2_s3;

		t_s5   <= t_s4;
		neg_s5 <= neg_s4;
		m_s5   <= acc5[30:0] * t2_s4;

		neg_s6 <= neg_s5;
		m_s6   <= acc6[30:0] * t_s5;

		sin_q30 <= neg_s6 ? -$signed(mag_cl) : $signed(mag_cl);
	end

endmodule

### src/lrw_oq.sv
// ----------------------------------------------------------------------------
// lrw_oq: output queue for finished points
// A small register queue that absorbs every beat still in the pipeline when
// the receiver stalls, so the pipeline itself never has to stop.
// ----------------------------------------------------------------------------
module lrw_oq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lrw_pkg::res_t  push_data,
	input  logic           pop,
	output logic           not_empty,
	output lrw_pkg::res_t  head
);

	lrw_pkg::res_t              mem [0:lrw_pkg::OQ_DEPTH-1];
	logic [lrw_pkg::OQ_AW-1:0] wr_ptr_q;
	logic [lrw_pkg::OQ_AW-1:0] rd_ptr_q;
	logic [lrw_pkg::OQ_AW:0]   fill_q;

	assign not_empty = (fill_q != '0);
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

### src/laser_ray_to_world_point_top.sv
// ----------------------------------------------------------------------------
// laser_ray_to_world_point_top: laser ray to world east/north point
// Channel  Direction  Handshake               Contents
// in       to block   in_valid / in_stall     ray index, range, pose, flags
// out      from block out_valid / out_stall   world point, ray number, status
// cfg      to block   cfg_valid / cfg_ready   register index and write data
// One ray enters per cycle while in_stall is low; its point then passes one
// stage for the ray angle, seven for the sine pipeline, five for scaling and
// the two rotations, and one for the write into the output queue.
// A 32-entry output queue holds results while the receiver stalls; the
// input stalls only once in-flight and queued beats fill that queue.
// Reset clears the valid bits, the queue and the registers to their defaults.
// ----------------------------------------------------------------------------
module laser_ray_to_world_point_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [11:0]        ray_index,
	input  logic [15:0]        range_mm,
	input  logic signed [31:0] pose_east_mm,
	input  logic signed [31:0] pose_north_mm,
	input  logic [15:0]        pose_heading,
	input  logic               pose_valid,
	input  logic               last_ray,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] point_east_mm,
	output logic signed [31:0] point_north_mm,
	output logic [11:0]        ray_number,
	output logic [1:0]         status,
	output logic               scan_end,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int LAST = 13;

	logic [15:0] start_angle_q, angle_step_q, range_floor_q, range_ceil_q;
	logic [15:0] mount_x_q, mount_y_q, mount_yaw_q;

	logic in_acc, out_acc;
	logic [lrw_pkg::OQ_AW:0] credit_q;

	lrw_pkg::meta_t  meta_in;
	logic [27:0]     ang_prod;
	logic [15:0]     ang_s1;
	logic [15:0]     head_s1;
	lrw_pkg::meta_t  meta_s [1:LAST];
	logic            v_s    [1:LAST];

	logic signed [31:0] rc, rs, mc, ms, hc, hs;

	logic signed [48:0] px_s9, py_s9;
	logic signed [31:0] mc_s9, ms_s9, hc_s9, hs_s9, hc_s10, hs_s10, hc_s11, hs_s11;
	logic signed [48:0] pxr, pyr;
	logic signed [58:0] a_s10, b_s10, c_s10, d_s10;
	logic signed [59:0] dx, dy, dxr, dyr;
	logic signed [30:0] bx_s11, by_s11;
	logic signed [62:0] e1_s12, e2_s12, n1_s12, n2_s12;
	logic signed [63:0] de, dn, der, dnr;
	logic signed [41:0] wx_s13, wy_s13;
	logic signed [41:0] wxr, wyr;
	logic signed [31:0] east_c, north_c;
	lrw_pkg::res_t      res_c;
	lrw_pkg::res_t      head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= '0;
			angle_step_q  <= '0;
			range_floor_q <= '0;
			range_ceil_q  <= 16'hFFFF;
			mount_x_q     <= '0;
			mount_y_q     <= '0;
			mount_yaw_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				lrw_pkg::REG_START_ANGLE: start_angle_q <= cfg_data;
				lrw_pkg::REG_ANGLE_STEP:  angle_step_q  <= cfg_data;
				lrw_pkg::REG_RANGE_FLOOR: range_floor_q <= cfg_data;
				lrw_pkg::REG_RANGE_CEIL:  range_ceil_q  <= cfg_data;
				lrw_pkg::REG_MOUNT_X:     mount_x_q     <= cfg_data;
				lrw_pkg::REG_MOUNT_Y:     mount_y_q     <= cfg_data;
				lrw_pkg::REG_MOUNT_YAW:   mount_yaw_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = (credit_q == (lrw_pkg::OQ_AW+1)'(lrw_pkg::OQ_DEPTH));
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	always_comb begin
		meta_in.idx   = ray_index;
		meta_in.last  = last_ray;
		meta_in.range = range_mm;
		meta_in.pe    = pose_east_mm;
		meta_in.pn    = pose_north_mm;
		if ((32'(ray_index) >= 32'(lrw_pkg::MAX_RAYS)) || (range_mm < range_floor_q) ||
			(range_mm > range_ceil_q)) begin
			meta_in.status = lrw_pkg::ST_RANGE;
		end else if (!pose_valid) begin
			meta_in.status = lrw_pkg::ST_POSE;
		end else begin
			meta_in.status = lrw_pkg::ST_OK;
		end
	end

	assign ang_prod = ray_index * angle_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST; k++) begin
				v_s[k] <= 1'b0;
			end
		end else begin
			v_s[1] <= in_acc;
			for (int k = 2; k <= LAST; k++) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		meta_s[1] <= meta_in;
		ang_s1    <= start_angle_q + ang_prod[15:0];
		head_s1   <= pose_heading;
		for (int k = 2; k <= LAST; k++) begin
			meta_s[k] <= meta_s[k-1];
		end
	end

	lrw_sin u_rs (.clk(clk), .angle(ang_s1), .sin_q30(rs));
	lrw_sin u_rc (.clk(clk), .angle(ang_s1 + lrw_pkg::QUARTER_TURN), .sin_q30(rc));
	lrw_sin u_ms (.clk(clk), .angle(mount_yaw_q), .sin_q30(ms));
	lrw_sin u_mc (.clk(clk), .angle(mount_yaw_q + lrw_pkg::QUARTER_TURN), .sin_q30(mc));
	lrw_sin u_hs (.clk(clk), .angle(head_s1), .sin_q30(hs));
	lrw_sin u_hc (.clk(clk), .angle(head_s1 + lrw_pkg::QUARTER_TURN), .sin_q30(hc));

	assign pxr = (px_s9 + (49'sd1 <<< 21)) >>> 22;
	assign pyr = (py_s9 + (49'sd1 <<< 21)) >>> 22;

	assign dx  = 60'(a_s10) - 60'(b_s10);
	assign dy  = 60'(c_s10) + 60'(d_s10);
	assign dxr = (dx + (60'sd1 <<< 29)) >>> 30;
	assign dyr = (dy + (60'sd1 <<< 29)) >>> 30;

	assign de  = 64'(e1_s12) - 64'(e2_s12);
	assign dn  = 64'(n1_s12) + 64'(n2_s12);
	assign der = (de + (64'sd1 <<< 29)) >>> 30;
	assign dnr = (dn + (64'sd1 <<< 29)) >>> 30;

	assign wxr = (wx_s13 + 42'sd128) >>> 8;
	assign wyr = (wy_s13 + 42'sd128) >>> 8;

	always_comb begin
		if (wxr > 42'sd2147483647) begin
			east_c = 32'sh7FFFFFFF;
		end else if (wxr < -42'sd2147483648) begin
			east_c = 32'sh80000000;
		end else begin
			east_c = $signed(wxr[31:0]);
		end
		if (wyr > 42'sd2147483647) begin
			north_c = 32'sh7FFFFFFF;
		end else if (wyr < -42'sd2147483648) begin
			north_c = 32'sh80000000;
		end else begin
			north_c = $signed(wyr[31:0]);
		end
	end

	always_ff @(posedge clk) begin
		px_s9 <= $signed({1'b0, meta_s[8].range}) * rc;
		py_s9 <= $signed({1'b0, meta_s[8].range}) * rs;
		mc_s9 <= mc;
		ms_s9 <= ms;
		hc_s9 <= hc;
		hs_s9 <= hs;

		a_s10  <= mc_s9 * $signed(pxr[26:0]);
		b_s10  <= ms_s9 * $signed(pyr[26:0]);
		c_s10  <= ms_s9 * $signed(pxr[26:0]);
		d_s10  <= mc_s9 * $signed(pyr[26:0]);
		hc_s10 <= hc_s9;
		hs_s10 <= hs_s9;

		bx_s11 <= 31'($signed({mount_x_q, 8'd0})) + $signed(dxr[30:0]);
		by_s11 <= 31'($signed({mount_y_q, 8'd0})) + $signed(dyr[30:0]);
		hc_s11 <= hc_s10;
		hs_s11 <= hs_s10;

		e1_s12 <= hc_s11 * bx_s11;
		e2_s12 <= hs_s11 * by_s11;
		n1_s12 <= hs_s11 * bx_s11;
		n2_s12 <= hc_s11 * by_s11;

		wx_s13 <= 42'($signed({meta_s[12].pe, 8'd0})) + $signed(der[41:0]);
		wy_s13 <= 42'($signed({meta_s[12].pn, 8'd0})) + $signed(dnr[41:0]);
	end

	always_comb begin
		res_c.ray_number = meta_s[LAST].idx;
		res_c.status     = meta_s[LAST].status;
		res_c.scan_end   = meta_s[LAST].last;
		if (meta_s[LAST].status == lrw_pkg::ST_OK) begin
			res_c.east  = east_c;
			res_c.north = north_c;
		end else begin
			res_c.east  = '0;
			res_c.north = '0;
		end
	end

	lrw_oq u_oq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s[LAST]),
		.push_data (res_c),
		.pop       (out_acc),
		.not_empty (out_valid),
		.head      (head)
	);

	assign point_east_mm  = head.east;
	assign point_north_mm = head.north;
	assign ray_number     = head.ray_number;
	assign status         = head.status;
	assign scan_end       = head.scan_end;

endmodule
